// ===== hw/rtl/rptp_pkg.sv =====
// shared types and constants of the runtime priority task picker
// no dependencies; rptp_score and the core refer to it by scoped names, the testbench imports it
`default_nettype none

package rptp_pkg;

  // command codes
  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_SCHEDULE = 1'b1;

  // task status codes
  localparam logic [1:0] ST_NOT_READY = 2'd0;
  localparam logic [1:0] ST_RUNNING   = 2'd1;
  localparam logic [1:0] ST_SLEEPING  = 2'd2;

  // sleep thresholds and penalty
  localparam logic [15:0] SLEEP_SOFT    = 16'd500;
  localparam logic [15:0] SLEEP_HARD    = 16'd2000;
  localparam int          HARD_PENALTY  = 10000;

  // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for y < 2**29
  localparam logic [29:0] RECIP_25      = 30'd687194768;
  localparam int          RECIP_SHIFT   = 34;

  // score range is about -21.8e6 .. 240
  localparam int SCORE_W = 27;

  typedef struct packed {
    logic [7:0]  id;
    logic [1:0]  status;
    logic [15:0] runtime;
    logic [7:0]  prio;
    logic [15:0] sleep;
  } slot_entry_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  slot;
    logic [7:0]  task_id;
    logic [1:0]  task_status;
    logic [15:0] recent_runtime;
    logic [7:0]  task_priority;
    logic [15:0] sleep_ticks;
    logic [7:0]  current_id;
  } task_req_t;

  typedef struct packed {
    logic       do_switch;
    logic [7:0] next_id;
  } task_rsp_t;

  // scored slot leaving the scoring pipeline
  typedef struct packed {
    logic                      vld;
    logic                      elig;
    logic signed [SCORE_W-1:0] score;
    slot_entry_t               entry;
  } score_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rptp_chan_if.sv =====
// valid/ready channel carrying one payload per transaction
// payload type is a parameter; used with types from rptp_pkg
`default_nettype none

interface rptp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rptp_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module rptp_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rptp_score.sv =====
// three stage scoring pipeline for one task slot per cycle
// depends on rptp_pkg for the slot entry, score result and constants
`default_nettype none

module rptp_score #(
  parameter int IDX_W = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_vld_i,
  input  wire logic [IDX_W-1:0]          in_idx_i,
  input  wire rptp_pkg::slot_entry_t     in_entry_i,
  output rptp_pkg::score_res_t           out_o,
  output logic      [IDX_W-1:0]          out_idx_o,
  output logic                           busy_o
);

  function automatic logic [4:0] floor_log2_17(input logic [16:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < 17; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // stage 1: squares, log2, flags
  logic                  v1_q;
  logic [IDX_W-1:0]      idx1_q;
  rptp_pkg::slot_entry_t ent1_q;
  logic                  elig1_q;
  logic [4:0]            lg1_q;
  logic [31:0]           sq1_q;
  logic [15:0]           p2_1_q;
  logic                  gt_soft1_q;
  logic                  gt_hard1_q;

  // stage 2: divide by 200, scale terms
  logic                  v2_q;
  logic [IDX_W-1:0]      idx2_q;
  rptp_pkg::slot_entry_t ent2_q;
  logic                  elig2_q;
  logic [8:0]            lg15_2_q;
  logic [18:0]           p5_2_q;
  logic [24:0]           q2_q;
  logic                  gt_soft2_q;
  logic                  gt_hard2_q;

  // stage 3: final score
  logic                                v3_q;
  logic [IDX_W-1:0]                    idx3_q;
  rptp_pkg::slot_entry_t               ent3_q;
  logic                                elig3_q;
  logic [rptp_pkg::SCORE_W-1:0]        score3_q;

  logic [16:0] rt_inc;
  logic [58:0] recip_prod;
  logic [rptp_pkg::SCORE_W-1:0] score_d;

  assign rt_inc     = {1'b0, in_entry_i.runtime} + 17'd1;
  assign recip_prod = {30'b0, sq1_q[31:3]} * {29'b0, rptp_pkg::RECIP_25};

  always_comb begin
    score_d = {18'b0, lg15_2_q} - {8'b0, p5_2_q};
    if (gt_soft2_q) score_d = score_d - {2'b0, q2_q};
    if (gt_hard2_q) score_d = score_d - rptp_pkg::SCORE_W'(rptp_pkg::HARD_PENALTY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q     <= in_idx_i;
    ent1_q     <= in_entry_i;
    elig1_q    <= (in_entry_i.id != 8'd0) &&
                  ((in_entry_i.status == rptp_pkg::ST_RUNNING) ||
                   (in_entry_i.status == rptp_pkg::ST_SLEEPING));
    lg1_q      <= floor_log2_17(rt_inc);
    sq1_q      <= {16'b0, in_entry_i.sleep} * {16'b0, in_entry_i.sleep};
    p2_1_q     <= {8'b0, in_entry_i.prio} * {8'b0, in_entry_i.prio};
    gt_soft1_q <= in_entry_i.sleep > rptp_pkg::SLEEP_SOFT;
    gt_hard1_q <= in_entry_i.sleep > rptp_pkg::SLEEP_HARD;

    idx2_q     <= idx1_q;
    ent2_q     <= ent1_q;
    elig2_q    <= elig1_q;
    lg15_2_q   <= {lg1_q, 4'b0} - {4'b0, lg1_q};
    p5_2_q     <= {1'b0, p2_1_q, 2'b0} + {3'b0, p2_1_q};
    q2_q       <= recip_prod[rptp_pkg::RECIP_SHIFT +: 25];
    gt_soft2_q <= gt_soft1_q;
    gt_hard2_q <= gt_hard1_q;

    idx3_q     <= idx2_q;
    ent3_q     <= ent2_q;
    elig3_q    <= elig2_q;
    score3_q   <= score_d;
  end

  assign out_o.vld   = v3_q;
  assign out_o.elig  = elig3_q;
  assign out_o.score = $signed(score3_q);
  assign out_o.entry = ent3_q;
  assign out_idx_o   = idx3_q;
  assign busy_o      = v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

// ===== hw/rtl/runtime_priority_task_picker_core.sv =====
// top level of the runtime priority task picker
// depends on rptp_pkg, rptp_chan_if, rptp_ram and rptp_score
`default_nettype none

// The block holds TASK_SLOTS task slots in a one-port-read, one-port-write RAM.
// A write transaction (cmd = write) loads one slot and answers do_switch = 0,
// next_id = 0; a write to a slot at or above TASK_SLOTS is dropped. A schedule
// transaction with run_enable set sweeps the RAM one slot per read cycle through
// a three stage scoring pipeline and a running minimum, the RAM read port
// setting the pace; with run_enable clear it answers zero. The first slot with
// the lowest score wins; if its id differs from current_id the winner's runtime
// is cleared by a write-back and do_switch is raised. One transaction is in work
// at a time. The result sits in an output register, so a new transaction is
// taken while the previous result still waits. Slots come out of reset empty
// through per-slot valid bits, with no clearing pass. run_enable is written on
// its own channel, which is always ready; the user must write it only while the
// block is idle, as the block itself does not enforce this.
module runtime_priority_task_picker_core #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  rptp_chan_if.sink    task_i,
  rptp_chan_if.sink    cfg_i,
  rptp_chan_if.source  result_o
);

  localparam int AW = $clog2(TASK_SLOTS);

  // fsm and control
  rptp_pkg::state_e state_q, state_d;
  logic             run_en_q;
  logic [TASK_SLOTS-1:0] slot_vld_q;
  logic [AW-1:0]    scan_cnt_q;

  // read stage tag, aligned with ram read data
  logic             issue_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_idx_q;

  // running minimum
  logic                                 found_q;
  logic signed [rptp_pkg::SCORE_W-1:0]  best_q;
  logic [AW-1:0]                        win_idx_q;
  rptp_pkg::slot_entry_t                win_entry_q;
  logic [7:0]                           cur_id_q;

  // pending result and output register
  rptp_pkg::task_rsp_t res_q;
  logic                out_vld_q;
  rptp_pkg::task_rsp_t out_data_q;

  // decoded controls
  logic task_fire;
  logic is_sched;
  logic in_range;
  logic out_free;
  logic scan_last;
  logic mem_re;
  logic table_wr;
  logic wb_wr;
  logic out_load;
  logic scan_start;

  logic [8:0]            slot_ext;
  logic [AW-1:0]         slot_addr;
  rptp_pkg::slot_entry_t wr_entry;
  rptp_pkg::slot_entry_t wb_entry;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  rptp_pkg::slot_entry_t mem_wdata;
  rptp_pkg::slot_entry_t mem_rdata;
  rptp_pkg::slot_entry_t rd_entry;

  rptp_pkg::score_res_t  sc_out;
  logic [AW-1:0]         sc_idx;
  logic                  sc_busy;
  logic                  sc_better;

  assign task_fire = task_i.valid & task_i.ready;
  assign is_sched  = task_i.data.cmd == rptp_pkg::CMD_SCHEDULE;
  assign slot_ext  = {5'b0, task_i.data.slot};
  assign in_range  = slot_ext < 9'(TASK_SLOTS);
  assign slot_addr = slot_ext[AW-1:0];
  assign out_free  = !out_vld_q || result_o.ready;
  assign scan_last = scan_cnt_q == AW'(TASK_SLOTS - 1);

  // the configuration channel never stalls
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rptp_pkg::ST_IDLE: begin
        if (task_fire) begin
          if (is_sched && run_en_q) state_d = rptp_pkg::ST_SCAN;
          else                      state_d = rptp_pkg::ST_RESULT;
        end
      end
      rptp_pkg::ST_SCAN: begin
        if (scan_last) state_d = rptp_pkg::ST_DRAIN;
      end
      rptp_pkg::ST_DRAIN: begin
        // last slot folded into the minimum once the pipeline is empty
        if (!issue_q && !sc_busy) state_d = rptp_pkg::ST_DECIDE;
      end
      rptp_pkg::ST_DECIDE: begin
        state_d = rptp_pkg::ST_RESULT;
      end
      rptp_pkg::ST_RESULT: begin
        if (out_free) state_d = rptp_pkg::ST_IDLE;
      end
      default: state_d = rptp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    task_i.ready = 1'b0;
    mem_re       = 1'b0;
    table_wr     = 1'b0;
    wb_wr        = 1'b0;
    out_load     = 1'b0;
    scan_start   = 1'b0;
    case (state_q)
      rptp_pkg::ST_IDLE: begin
        task_i.ready = 1'b1;
        table_wr     = task_fire && !is_sched && in_range;
        scan_start   = task_fire && is_sched && run_en_q;
      end
      rptp_pkg::ST_SCAN: begin
        mem_re = 1'b1;
      end
      rptp_pkg::ST_DECIDE: begin
        wb_wr = found_q && (win_entry_q.id != cur_id_q);
      end
      rptp_pkg::ST_RESULT: begin
        out_load = out_free;
      end
      default: begin
        task_i.ready = 1'b0;
      end
    endcase
  end

  // slot image for a write transaction
  always_comb begin
    wr_entry.id      = task_i.data.task_id;
    wr_entry.status  = task_i.data.task_status;
    wr_entry.runtime = task_i.data.recent_runtime;
    wr_entry.prio    = task_i.data.task_priority;
    wr_entry.sleep   = task_i.data.sleep_ticks;
  end

  // winner write-back with runtime cleared
  always_comb begin
    wb_entry         = win_entry_q;
    wb_entry.runtime = '0;
  end

  assign mem_we    = table_wr | wb_wr;
  assign mem_waddr = wb_wr ? win_idx_q : slot_addr;
  assign mem_wdata = wb_wr ? wb_entry : wr_entry;

  rptp_ram #(
    .WIDTH ($bits(rptp_pkg::slot_entry_t)),
    .DEPTH (TASK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (scan_cnt_q),
    .rdata_o (mem_rdata)
  );

  // a slot never written since reset reads as empty
  assign rd_entry = rd_vld_q ? mem_rdata : '0;

  rptp_score #(
    .IDX_W (AW)
  ) u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (issue_q),
    .in_idx_i   (rd_idx_q),
    .in_entry_i (rd_entry),
    .out_o      (sc_out),
    .out_idx_o  (sc_idx),
    .busy_o     (sc_busy)
  );

  // strict less-than keeps the first of equal scores
  assign sc_better = sc_out.vld && sc_out.elig && (!found_q || (sc_out.score < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rptp_pkg::ST_IDLE;
      run_en_q   <= 1'b0;
      slot_vld_q <= '0;
      scan_cnt_q <= '0;
      issue_q    <= 1'b0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        run_en_q <= cfg_i.data;
      end
      if (table_wr) begin
        slot_vld_q[slot_addr] <= 1'b1;
      end
      // scan address walks 0 .. TASK_SLOTS-1
      if (scan_start) begin
        scan_cnt_q <= '0;
      end else if (mem_re && !scan_last) begin
        scan_cnt_q <= scan_cnt_q + AW'(1);
      end
      issue_q <= mem_re;
      if (scan_start) begin
        found_q <= 1'b0;
      end else if (sc_better) begin
        found_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= slot_vld_q[scan_cnt_q];
    rd_idx_q <= scan_cnt_q;
    if (scan_start) begin
      cur_id_q <= task_i.data.current_id;
    end
    if (sc_better) begin
      best_q      <= sc_out.score;
      win_idx_q   <= sc_idx;
      win_entry_q <= sc_out.entry;
    end
    // write and disabled schedule answer zero, a scan answers at decide
    if (task_fire) begin
      res_q <= '0;
    end else if (state_q == rptp_pkg::ST_DECIDE) begin
      res_q.do_switch <= found_q && (win_entry_q.id != cur_id_q);
      res_q.next_id   <= found_q ? win_entry_q.id : 8'd0;
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_data_q;

endmodule

`default_nettype wire

// ===== tb/rptp_checker.sv =====
// scoreboard for the runtime priority task picker: keeps its own task table,
// predicts do_switch/next_id for each task transaction and compares results
// depends on rptp_pkg for the transaction and slot types
module rptp_checker #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                task_valid_i,
  input  logic                task_ready_i,
  input  rptp_pkg::task_req_t task_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  input  logic                rsp_valid_i,
  input  logic                rsp_ready_i,
  input  rptp_pkg::task_rsp_t rsp_data_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  switch_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rptp_pkg::*;

  slot_entry_t tasks_q [TASK_SLOTS];
  task_rsp_t   picks_q [$];
  task_rsp_t   want;
  logic        sched_on;
  int          fails;
  int          checked;
  int          switches;

  // 15*floor(log2(runtime+1)) - 5*prio^2 - sleep penalties, in 64 bits
  function automatic longint task_score(slot_entry_t e);
    longint     s;
    longint     sl;
    int         lg;
    logic [16:0] r;
    r  = {1'b0, e.runtime} + 17'd1;
    lg = 0;
    while (r > 17'd1) begin
      r  = r >> 1;
      lg = lg + 1;
    end
    sl = longint'(e.sleep);
    s  = 15 * lg - 5 * longint'(e.prio) * longint'(e.prio);
    if (sl > longint'(SLEEP_SOFT)) begin
      s = s - (sl * sl) / 200;
    end
    if (sl > longint'(SLEEP_HARD)) begin
      s = s - HARD_PENALTY;
    end
    return s;
  endfunction

  // applies one task transaction to the table and returns the pick it causes
  function automatic task_rsp_t predict_pick(task_req_t req);
    task_rsp_t r;
    longint    best;
    longint    sc;
    bit        found;
    int        win;
    r     = '0;
    best  = 0;
    found = 0;
    win   = 0;
    if (req.cmd == CMD_WRITE) begin
      if (int'(req.slot) < TASK_SLOTS) begin
        tasks_q[req.slot] = '{id: req.task_id, status: req.task_status,
                              runtime: req.recent_runtime, prio: req.task_priority,
                              sleep: req.sleep_ticks};
      end
      return r;
    end
    if (!sched_on) begin
      return r;
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (tasks_q[i].id != 8'd0 &&
          (tasks_q[i].status == ST_RUNNING || tasks_q[i].status == ST_SLEEPING)) begin
        sc = task_score(tasks_q[i]);
        if (!found || sc < best) begin
          best  = sc;
          win   = i;
          found = 1;
        end
      end
    end
    if (found) begin
      r.next_id = tasks_q[win].id;
      if (tasks_q[win].id != req.current_id) begin
        tasks_q[win].runtime = '0;
        r.do_switch          = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tasks_q[i] = '0;
      end
      picks_q.delete();
      sched_on = 1'b0;
      fails    = 0;
      checked  = 0;
      switches = 0;
    end else begin
      // result side first: a result never belongs to a transaction of the same edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (picks_q.size() == 0) begin
          $error("result with nothing expected: do_switch %0d next_id %0d",
                 rsp_data_i.do_switch, rsp_data_i.next_id);
          fails = fails + 1;
        end else begin
          want    = picks_q.pop_front();
          checked = checked + 1;
          if (want.do_switch) begin
            switches = switches + 1;
          end
          if (rsp_data_i.do_switch !== want.do_switch) begin
            $error("do_switch: expected %0d, actual %0d", want.do_switch,
                   rsp_data_i.do_switch);
            fails = fails + 1;
          end
          if (rsp_data_i.next_id !== want.next_id) begin
            $error("next_id: expected %0d, actual %0d", want.next_id,
                   rsp_data_i.next_id);
            fails = fails + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        sched_on = cfg_data_i;
      end
      if (task_valid_i && task_ready_i) begin
        picks_q.push_back(predict_pick(task_data_i));
      end
    end
    fail_cnt_o   <= fails;
    pending_o    <= picks_q.size();
    checked_o    <= checked;
    switch_cnt_o <= switches;
  end

endmodule

// ===== tb/tb.sv =====
// top of the task picker testbench: clock, reset, stimulus and verdict
// depends on rptp_pkg, rptp_chan_if, runtime_priority_task_picker_core, rptp_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rptp_pkg::*;

  localparam int TASK_SLOTS  = 16;
  // a schedule sweep is the slowest transaction
  localparam int LATENCY     = TASK_SLOTS + 8;
  // cycles of quiet after the last result so a write-back can land
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  // status code with no meaning, must be treated as not ready
  localparam logic [1:0] ST_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rptp_chan_if #(.payload_t(task_req_t)) task_if ();
  rptp_chan_if #(.payload_t(logic))      cfg_if ();
  rptp_chan_if #(.payload_t(task_rsp_t)) result_if ();

  int tx_idle_pct = 16;
  int rx_idle_pct = 69;
  int hold_req    = 0;
  int n_sent      = 0;
  int n_sched     = 0;
  int quiet       = 0;
  int fail_cnt;
  int pending;
  int checked;
  int switches;

  always #10 clk_i = ~clk_i;

  runtime_priority_task_picker_core #(
    .TASK_SLOTS(TASK_SLOTS)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .task_i  (task_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  rptp_checker #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .task_valid_i(task_if.valid),
    .task_ready_i(task_if.ready),
    .task_data_i (task_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .rsp_valid_i (result_if.valid),
    .rsp_ready_i (result_if.ready),
    .rsp_data_i  (result_if.data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .switch_cnt_o(switches)
  );

  // result receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_seen;
    hold_seen       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        // hold-off counted here while the sender keeps offering transactions
        hold_seen = hold_req;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog: too many cycles without any handshake ends the run
  always @(posedge clk_i) begin
    if ((task_if.valid && task_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic task_req_t slot_write(logic [3:0] s, logic [7:0] id, logic [1:0] st,
                                           logic [15:0] rt, logic [7:0] pr,
                                           logic [15:0] sl);
    task_req_t r;
    r                = '0;
    r.cmd            = CMD_WRITE;
    r.slot           = s;
    r.task_id        = id;
    r.task_status    = st;
    r.recent_runtime = rt;
    r.task_priority  = pr;
    r.sleep_ticks    = sl;
    return r;
  endfunction

  function automatic task_req_t sched_pick(logic [7:0] cur);
    task_req_t r;
    r            = '0;
    r.cmd        = CMD_SCHEDULE;
    r.current_id = cur;
    return r;
  endfunction

  // offer one task transaction; valid stays high afterwards unless a gap follows
  task automatic push_task(input task_req_t req);
    if ($urandom_range(99) < tx_idle_pct) begin
      task_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    task_if.valid <= 1'b1;
    task_if.data  <= req;
    do @(posedge clk_i); while (!task_if.ready);
    n_sent = n_sent + 1;
    if (req.cmd == CMD_SCHEDULE) begin
      n_sched = n_sched + 1;
    end
  endtask

  // stop offering and wait until every expected result is in
  task automatic drain();
    task_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // run_enable is written only with the block idle
  task automatic set_run_enable(input logic en);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= en;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // random transactions: a small id pool so duplicates and current-id hits are common,
  // sleep values clustered around the penalty thresholds
  task automatic run_random(input int n);
    task_req_t r;
    for (int k = 0; k < n; k++) begin
      r = task_req_t'({$urandom, $urandom, $urandom});
      r.cmd = ($urandom_range(99) < 35) ? CMD_SCHEDULE : CMD_WRITE;
      case ($urandom_range(9))
        0:       r.task_id = 8'd0;
        1, 2:    r.task_id = 8'($urandom_range(255));
        default: r.task_id = 8'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3:    r.task_status = ST_RUNNING;
        4, 5, 6, 7:    r.task_status = ST_SLEEPING;
        8:             r.task_status = ST_NOT_READY;
        default:       r.task_status = ST_UNUSED;
      endcase
      case ($urandom_range(3))
        0:       r.recent_runtime = 16'($urandom_range(65535));
        1:       r.recent_runtime = 16'($urandom_range(255));
        2:       r.recent_runtime = ($urandom_range(1)) ? 16'hffff : 16'h0000;
        default: r.recent_runtime = 16'((32'd1 << $urandom_range(16)) - 1);
      endcase
      case ($urandom_range(3))
        0:       r.task_priority = 8'($urandom_range(255));
        default: r.task_priority = 8'($urandom_range(15));
      endcase
      case ($urandom_range(5))
        0:       r.sleep_ticks = 16'($urandom_range(65535));
        1:       r.sleep_ticks = 16'($urandom_range(400, 2200));
        2:       r.sleep_ticks = 16'($urandom_range(500));
        3:       r.sleep_ticks = 16'hffff;
        4:       r.sleep_ticks = 16'($urandom_range(490, 510));
        default: r.sleep_ticks = 16'($urandom_range(1990, 2010));
      endcase
      if ($urandom_range(9) != 0) begin
        r.current_id = 8'($urandom_range(12));
      end
      push_task(r);
    end
  endtask

  initial begin
    task_if.valid = 1'b0;
    task_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scheduler still disabled after reset, empty table and then one task
    push_task(sched_pick(8'd0));
    push_task(slot_write(4'd2, 8'd5, ST_RUNNING, 16'd10, 8'd3, 16'd0));
    push_task(sched_pick(8'd0));
    set_run_enable(1'b1);
    // winner is the current task: no switch, runtime kept
    push_task(sched_pick(8'd5));
    // winner differs: switch and runtime cleared
    push_task(sched_pick(8'd0));
    // field extremes, empty slot, not ready and the unused status code
    push_task(slot_write(4'd0, 8'd255, ST_RUNNING, 16'hffff, 8'd0, 16'd0));
    push_task(slot_write(4'd15, 8'd1, ST_SLEEPING, 16'd0, 8'd255, 16'hffff));
    push_task(slot_write(4'd4, 8'd7, ST_UNUSED, 16'd0, 8'd255, 16'hffff));
    push_task(slot_write(4'd5, 8'd9, ST_NOT_READY, 16'd0, 8'd255, 16'hffff));
    push_task(slot_write(4'd3, 8'd0, ST_RUNNING, 16'd0, 8'd255, 16'hffff));
    push_task(sched_pick(8'd1));
    // duplicate id with a tied score: the lower slot wins and is the one cleared
    push_task(slot_write(4'd6, 8'd1, ST_RUNNING, 16'd0, 8'd255, 16'hffff));
    push_task(sched_pick(8'd2));
    push_task(slot_write(4'd6, 8'd1, ST_NOT_READY, 16'd0, 8'd255, 16'hffff));
    push_task(slot_write(4'd15, 8'd1, ST_NOT_READY, 16'd0, 8'd255, 16'hffff));
    // sleep right at and just past both thresholds
    push_task(slot_write(4'd10, 8'd40, ST_SLEEPING, 16'd0, 8'd0, 16'd500));
    push_task(slot_write(4'd11, 8'd41, ST_SLEEPING, 16'd0, 8'd0, 16'd501));
    push_task(slot_write(4'd12, 8'd42, ST_RUNNING, 16'd0, 8'd0, 16'd2000));
    push_task(slot_write(4'd13, 8'd43, ST_SLEEPING, 16'd0, 8'd0, 16'd2001));
    push_task(sched_pick(8'd0));
    push_task(slot_write(4'd13, 8'd43, ST_NOT_READY, 16'd0, 8'd0, 16'd2001));
    push_task(sched_pick(8'd42));
    push_task(slot_write(4'd12, 8'd42, ST_NOT_READY, 16'd0, 8'd0, 16'd2000));
    push_task(sched_pick(8'd0));

    // sender lightly idle, receiver mostly stalled; scheduler toggled off and on
    run_random(400);
    set_run_enable(1'b0);
    run_random(80);
    set_run_enable(1'b1);
    run_random(80);

    // roles swapped
    tx_idle_pct = 69;
    rx_idle_pct = 16;
    run_random(350);

    // no idling; long receiver hold-off so the block backs up, then a full pause
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = hold_req + 1;
    run_random(150);
    drain();
    run_random(250);

    task_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("covered %0d task transactions (%0d schedule decisions, %0d switches)",
             n_sent, n_sched, switches);
    $display("%0d results checked, %0d mismatches", checked, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
